/* hdl/led_chain_pulse_width_encoder_macros.svh */
// assertion macros used by the checker file
`ifndef LED_CHAIN_PULSE_WIDTH_ENCODER_MACROS_SVH
`define LED_CHAIN_PULSE_WIDTH_ENCODER_MACROS_SVH

// same-cycle implication
`define LCPWE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("lcpwe check failed");

// next-cycle implication
`define LCPWE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("lcpwe check failed");

`endif

/* hdl/lcpwe_pkg.sv */
// shared types and constants of the led chain pulse width encoder
`timescale 1ns / 1ps

package lcpwe_pkg;

  localparam int PIXEL_W   = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_NUM   = 4;

  localparam int DEF_BITS_PER_PIXEL    = 24;
  localparam int DEF_TICK_COUNTER_BITS = 16;

  localparam logic [CFG_W-1:0] RST_ZERO_HIGH = 16'd25;
  localparam logic [CFG_W-1:0] RST_ONE_HIGH  = 16'd100;
  localparam logic [CFG_W-1:0] RST_PERIOD    = 16'd125;
  localparam logic [CFG_W-1:0] RST_LATCH_LOW = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_HIGH  = 2'd0,
    REG_ONE_HIGH   = 2'd1,
    REG_BIT_PERIOD = 2'd2,
    REG_LATCH_LOW  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel_word;
    logic               last_pixel;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic load_accepted;
    logic busy_res;
    logic frame_done;
    logic underrun;
  } res_t;

endpackage

/* hdl/lcpwe_cfg.sv */
// timing register file with saturation to the tick counter width
`timescale 1ns / 1ps

module lcpwe_cfg #(
  parameter int TICK_COUNTER_BITS = lcpwe_pkg::DEF_TICK_COUNTER_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lcpwe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcpwe_pkg::CFG_W-1:0]         cfg_wdata,
  output logic [TICK_COUNTER_BITS-1:0]        zero_high,
  output logic [TICK_COUNTER_BITS-1:0]        one_high,
  output logic [TICK_COUNTER_BITS-1:0]        bit_period,
  output logic [TICK_COUNTER_BITS-1:0]        latch_low
);
  import lcpwe_pkg::*;

  logic [CFG_W-1:0]             cfg_r [CFG_NUM];
  logic [TICK_COUNTER_BITS-1:0] sat   [CFG_NUM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_ZERO_HIGH]  <= RST_ZERO_HIGH;
      cfg_r[REG_ONE_HIGH]   <= RST_ONE_HIGH;
      cfg_r[REG_BIT_PERIOD] <= RST_PERIOD;
      cfg_r[REG_LATCH_LOW]  <= RST_LATCH_LOW;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ZERO_HIGH:  cfg_r[REG_ZERO_HIGH]  <= cfg_wdata;
        REG_ONE_HIGH:   cfg_r[REG_ONE_HIGH]   <= cfg_wdata;
        REG_BIT_PERIOD: cfg_r[REG_BIT_PERIOD] <= cfg_wdata;
        REG_LATCH_LOW:  cfg_r[REG_LATCH_LOW]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < CFG_NUM; g++) begin : g_sat
    if (TICK_COUNTER_BITS >= CFG_W) begin : g_wide
      assign sat[g] = TICK_COUNTER_BITS'(cfg_r[g]);
    end else begin : g_narrow
      // clip to the largest count
      assign sat[g] = (cfg_r[g][CFG_W-1:TICK_COUNTER_BITS] != '0) ? '1
                    : cfg_r[g][TICK_COUNTER_BITS-1:0];
    end
  end

  assign zero_high  = sat[REG_ZERO_HIGH];
  assign one_high   = sat[REG_ONE_HIGH];
  assign bit_period = sat[REG_BIT_PERIOD];
  assign latch_low  = sat[REG_LATCH_LOW];

endmodule

/* hdl/lcpwe_core.sv */
// encoder state and one-tick step logic
`timescale 1ns / 1ps

module lcpwe_core #(
  parameter int BITS_PER_PIXEL    = lcpwe_pkg::DEF_BITS_PER_PIXEL,
  parameter int TICK_COUNTER_BITS = lcpwe_pkg::DEF_TICK_COUNTER_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  lcpwe_pkg::item_t             item,
  input  logic [TICK_COUNTER_BITS-1:0] zero_high,
  input  logic [TICK_COUNTER_BITS-1:0] one_high,
  input  logic [TICK_COUNTER_BITS-1:0] bit_period,
  input  logic [TICK_COUNTER_BITS-1:0] latch_low,
  output lcpwe_pkg::res_t              res
);
  import lcpwe_pkg::*;

  localparam int BL_W = $clog2(BITS_PER_PIXEL + 1);
  localparam logic [TICK_COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam logic [BL_W-1:0] BL_FULL = BL_W'(BITS_PER_PIXEL);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BITS  = 2'd1,
    PH_LATCH = 2'd2
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [BITS_PER_PIXEL-1:0]    shift_r, shift_nxt;
  logic [BL_W-1:0]              bits_left_r, bits_left_nxt;
  logic [TICK_COUNTER_BITS-1:0] tick_r, tick_nxt;
  logic [BITS_PER_PIXEL-1:0]    hold_word_r, hold_word_nxt;
  logic                         hold_full_r, hold_full_nxt;
  logic                         hold_last_r, hold_last_nxt;
  logic                         cur_last_r, cur_last_nxt;
  logic [BITS_PER_PIXEL-1:0]    load_word;

  // fit the offered word to the pixel width
  if (BITS_PER_PIXEL > PIXEL_W) begin : g_ext
    assign load_word = BITS_PER_PIXEL'(item.pixel_word);
  end else begin : g_cut
    assign load_word = item.pixel_word[BITS_PER_PIXEL-1:0];
  end

  always_comb begin
    logic [TICK_COUNTER_BITS-1:0] high;
    logic [TICK_COUNTER_BITS-1:0] tick_inc;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    tick_nxt      = tick_r;
    hold_word_nxt = hold_word_r;
    hold_full_nxt = hold_full_r;
    hold_last_nxt = hold_last_r;
    cur_last_nxt  = cur_last_r;
    res           = '0;
    high          = '0;
    tick_inc      = '0;
    if (item.kind == KIND_LOAD) begin
      if (!hold_full_r) begin
        hold_word_nxt     = load_word;
        hold_last_nxt     = item.last_pixel;
        hold_full_nxt     = 1'b1;
        res.load_accepted = 1'b1;
      end
      res.busy_res = (phase_r != PH_IDLE);
    end else begin
      // start of a frame on this same tick
      if (phase_r == PH_IDLE && hold_full_r) begin
        shift_nxt     = hold_word_r;
        cur_last_nxt  = hold_last_r;
        hold_full_nxt = 1'b0;
        bits_left_nxt = BL_FULL;
        tick_nxt      = '0;
        phase_nxt     = PH_BITS;
      end
      unique case (phase_nxt)
        PH_BITS: begin
          high           = shift_nxt[BITS_PER_PIXEL-1] ? one_high : zero_high;
          res.busy_res   = 1'b1;
          res.line_level = (tick_nxt < high);
          tick_inc       = (tick_nxt == CNT_MAX) ? tick_nxt : tick_nxt + 1'b1;
          tick_nxt       = tick_inc;
          if (tick_inc >= bit_period) begin
            tick_nxt  = '0;
            shift_nxt = shift_nxt << 1;
            if (bits_left_nxt != '0) begin
              bits_left_nxt = bits_left_nxt - 1'b1;
            end
            if (bits_left_nxt == '0) begin
              priority if (cur_last_nxt) begin
                phase_nxt = PH_LATCH;
              end else if (hold_full_nxt) begin
                shift_nxt     = hold_word_r;
                cur_last_nxt  = hold_last_r;
                hold_full_nxt = 1'b0;
                bits_left_nxt = BL_FULL;
                tick_nxt      = '0;
                phase_nxt     = PH_BITS;
              end else begin
                res.underrun = 1'b1;
                phase_nxt    = PH_LATCH;
              end
            end
          end
        end
        PH_LATCH: begin
          res.busy_res = 1'b1;
          tick_inc     = (tick_nxt == CNT_MAX) ? tick_nxt : tick_nxt + 1'b1;
          tick_nxt     = tick_inc;
          if (tick_inc >= latch_low) begin
            tick_nxt       = '0;
            res.frame_done = 1'b1;
            phase_nxt      = PH_IDLE;
          end
        end
        PH_IDLE: ;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= '0;
      bits_left_r <= '0;
      tick_r      <= '0;
      hold_full_r <= 1'b0;
      hold_last_r <= 1'b0;
      cur_last_r  <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      tick_r      <= tick_nxt;
      hold_full_r <= hold_full_nxt;
      hold_last_r <= hold_last_nxt;
      cur_last_r  <= cur_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      hold_word_r <= hold_word_nxt;
    end
  end

endmodule

/* hdl/led_chain_pulse_width_encoder.sv */
// top level of the led chain pulse width encoder
//
//  channel | direction | handshake            | payload
//  in_     | request   | in_valid / in_ready  | kind, pixel_word, last_pixel
//  out_    | result    | out_valid/out_ready  | line_level .. underrun
//  cfg_    | write     | cfg_wr_en            | cfg_index, cfg_wdata
//
// one request per clock unless out_ready stalls; input register, then result register
// the tick step is one compare and increment on the tick counter between the two registers
// a stalled result holds the result register; one more request waits in the input register
// reset is synchronous and active low; timing registers return to 25, 100, 125, 3000
`timescale 1ns / 1ps

module led_chain_pulse_width_encoder #(
  parameter int BITS_PER_PIXEL    = lcpwe_pkg::DEF_BITS_PER_PIXEL,
  parameter int TICK_COUNTER_BITS = lcpwe_pkg::DEF_TICK_COUNTER_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [lcpwe_pkg::PIXEL_W-1:0]   in_pixel_word,
  input  logic                            in_last_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_line_level,
  output logic                            out_load_accepted,
  output logic                            out_busy_res,
  output logic                            out_frame_done,
  output logic                            out_underrun,
  input  logic                            cfg_wr_en,
  input  logic [lcpwe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcpwe_pkg::CFG_W-1:0]     cfg_wdata
);
  import lcpwe_pkg::*;

  logic                         s1_valid_r;
  item_t                        s1_item_r;
  logic                         out_valid_r;
  res_t                         out_res_r;
  res_t                         step_res;
  logic                         advance;
  logic                         step_en;
  logic [TICK_COUNTER_BITS-1:0] zero_high, one_high, bit_period, latch_low;

  assign advance  = !out_valid_r || out_ready;
  assign step_en  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  lcpwe_cfg #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .zero_high  (zero_high),
    .one_high   (one_high),
    .bit_period (bit_period),
    .latch_low  (latch_low)
  );

  lcpwe_core #(
    .BITS_PER_PIXEL   (BITS_PER_PIXEL),
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .item       (s1_item_r),
    .zero_high  (zero_high),
    .one_high   (one_high),
    .bit_period (bit_period),
    .latch_low  (latch_low),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.kind       <= in_kind;
      s1_item_r.pixel_word <= in_pixel_word;
      s1_item_r.last_pixel <= in_last_pixel;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_level    = out_res_r.line_level;
  assign out_load_accepted = out_res_r.load_accepted;
  assign out_busy_res      = out_res_r.busy_res;
  assign out_frame_done    = out_res_r.frame_done;
  assign out_underrun      = out_res_r.underrun;

endmodule

/* hdl/lcpwe_checker.sv */
// port-level checks on the encoder and their binding
`timescale 1ns / 1ps
`include "led_chain_pulse_width_encoder_macros.svh"

module lcpwe_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_line_level,
  input logic out_load_accepted,
  input logic out_busy_res,
  input logic out_frame_done,
  input logic out_underrun
);

  `LCPWE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `LCPWE_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_line_level) && $stable(out_load_accepted) && $stable(out_frame_done))
  `LCPWE_ASSERT_IMP(a_load_quiet, clk, rst_n, out_valid && out_load_accepted, !out_line_level && !out_frame_done && !out_underrun)
  `LCPWE_ASSERT_IMP(a_done_in_gap, clk, rst_n, out_valid && out_frame_done, out_busy_res && !out_line_level && !out_underrun)
  `LCPWE_ASSERT_IMP(a_underrun_busy, clk, rst_n, out_valid && out_underrun, out_busy_res)

endmodule

bind led_chain_pulse_width_encoder lcpwe_checker u_lcpwe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_line_level    (out_line_level),
  .out_load_accepted (out_load_accepted),
  .out_busy_res      (out_busy_res),
  .out_frame_done    (out_frame_done),
  .out_underrun      (out_underrun)
);

/* bench/led_chain_pulse_width_encoder_tb.sv */
// self-checking bench for the led chain pulse width encoder: directed table, then random frames
`timescale 1ns / 1ps

module led_chain_pulse_width_encoder_tb;
  import lcpwe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;

  typedef enum logic [1:0] {
    ENC_IDLE,
    ENC_BITS,
    ENC_LATCH
  } enc_state_t;

  typedef struct {
    kind_t              kind;
    logic [PIXEL_W-1:0] word;
    logic               last;
    int                 reps;
    bit                 typed;
    res_t               res;
  } drive_row_t;

  localparam res_t RES_QUIET = '0;
  localparam res_t RES_TAKEN = '{load_accepted: 1'b1, default: 1'b0};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = 1'b0;
  logic [PIXEL_W-1:0]   in_pixel_word = '0;
  logic                 in_last_pixel = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_line_level;
  logic                 out_load_accepted;
  logic                 out_busy_res;
  logic                 out_frame_done;
  logic                 out_underrun;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // encoder mirror
  logic [CFG_W-1:0]   t_zero_high, t_one_high, t_period, t_latch;
  logic [PIXEL_W-1:0] sr_word, held_word;
  logic [4:0]         bits_to_send;
  logic [CFG_W-1:0]   tick_cnt;
  logic               held_valid, held_last, sending_last;
  enc_state_t         enc_state;

  res_t expected_line_q [$];
  bit   use_typed = 1'b0;
  res_t typed_res = '0;
  bit   sender_idles = 1'b0;
  bit   receiver_stalls = 1'b0;
  int   stall_left = 0;
  int   starve_left = 0;
  int   pixels_to_go = 1;
  int   cycle_count = 0;
  int   fail_count = 0;
  int   requests_taken = 0;
  int   pixels_taken = 0;
  int   loads_refused = 0;
  int   frames_latched = 0;
  int   underruns_seen = 0;

  drive_row_t directed_rows [14] = '{
    '{KIND_TICK, 24'h000000, 1'b0, 1,  1'b1, RES_QUIET},
    '{KIND_LOAD, 24'hFFFFFF, 1'b0, 1,  1'b1, RES_TAKEN},
    '{KIND_LOAD, 24'h000000, 1'b1, 1,  1'b1, RES_QUIET},
    '{KIND_TICK, 24'h000000, 1'b0, 1,  1'b0, RES_QUIET},
    '{KIND_LOAD, 24'hA5A5A5, 1'b1, 1,  1'b0, RES_QUIET},
    '{KIND_LOAD, 24'h5A5A5A, 1'b0, 1,  1'b0, RES_QUIET},
    '{KIND_TICK, 24'h000000, 1'b0, 23, 1'b0, RES_QUIET},
    '{KIND_TICK, 24'h000000, 1'b0, 24, 1'b0, RES_QUIET},
    '{KIND_TICK, 24'h000000, 1'b0, 1,  1'b0, RES_QUIET},
    '{KIND_LOAD, 24'h123456, 1'b0, 1,  1'b1, RES_TAKEN},
    '{KIND_TICK, 24'h000000, 1'b0, 24, 1'b0, RES_QUIET},
    '{KIND_LOAD, 24'h800001, 1'b1, 1,  1'b0, RES_QUIET},
    '{KIND_TICK, 24'h000000, 1'b0, 1,  1'b0, RES_QUIET},
    '{KIND_TICK, 24'h000000, 1'b0, 3,  1'b0, RES_QUIET}
  };

  led_chain_pulse_width_encoder dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_encoder_mirror();
    t_zero_high  = RST_ZERO_HIGH;
    t_one_high   = RST_ONE_HIGH;
    t_period     = RST_PERIOD;
    t_latch      = RST_LATCH_LOW;
    sr_word      = '0;
    held_word    = '0;
    bits_to_send = '0;
    tick_cnt     = '0;
    held_valid   = 1'b0;
    held_last    = 1'b0;
    sending_last = 1'b0;
    enc_state    = ENC_IDLE;
  endfunction

  function automatic void load_shifter();
    sr_word      = held_word;
    sending_last = held_last;
    held_valid   = 1'b0;
    bits_to_send = 5'(DEF_BITS_PER_PIXEL);
    tick_cnt     = '0;
    enc_state    = ENC_BITS;
  endfunction

  function automatic res_t encode_item(input logic kind, input logic [PIXEL_W-1:0] word,
                                       input logic last);
    res_t             r;
    logic [CFG_W-1:0] high_ticks;
    r = '0;
    if (kind == KIND_LOAD) begin
      if (!held_valid) begin
        held_word       = word;
        held_last       = last;
        held_valid      = 1'b1;
        r.load_accepted = 1'b1;
      end
      r.busy_res = (enc_state != ENC_IDLE);
    end else begin
      if (enc_state == ENC_IDLE && held_valid) load_shifter();
      if (enc_state == ENC_BITS) begin
        high_ticks   = sr_word[PIXEL_W-1] ? t_one_high : t_zero_high;
        r.busy_res   = 1'b1;
        r.line_level = (tick_cnt < high_ticks);
        if (tick_cnt != '1) tick_cnt++;
        if (tick_cnt >= t_period) begin
          tick_cnt = '0;
          sr_word  = sr_word << 1;
          if (bits_to_send != 0) bits_to_send--;
          if (bits_to_send == 0) begin
            if (sending_last) begin
              enc_state = ENC_LATCH;
            end else if (held_valid) begin
              load_shifter();
            end else begin
              r.underrun = 1'b1;
              enc_state  = ENC_LATCH;
            end
          end
        end
      end else if (enc_state == ENC_LATCH) begin
        r.busy_res = 1'b1;
        if (tick_cnt != '1) tick_cnt++;
        if (tick_cnt >= t_latch) begin
          tick_cnt     = '0;
          r.frame_done = 1'b1;
          enc_state    = ENC_IDLE;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0b got %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t predicted;
    res_t want;
    cycle_count++;
    if (!rst_n) begin
      reset_encoder_mirror();
      expected_line_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ZERO_HIGH:  t_zero_high = cfg_wdata;
          REG_ONE_HIGH:   t_one_high  = cfg_wdata;
          REG_BIT_PERIOD: t_period    = cfg_wdata;
          REG_LATCH_LOW:  t_latch     = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_line_q.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none got line %0b", $time, out_line_level);
        end else begin
          want = expected_line_q.pop_front();
          check_field("line_level", want.line_level, out_line_level);
          check_field("load_accepted", want.load_accepted, out_load_accepted);
          check_field("busy_res", want.busy_res, out_busy_res);
          check_field("frame_done", want.frame_done, out_frame_done);
          check_field("underrun", want.underrun, out_underrun);
        end
      end
      if (in_valid && in_ready) begin
        predicted = encode_item(in_kind, in_pixel_word, in_last_pixel);
        requests_taken++;
        if (predicted.load_accepted) pixels_taken++;
        if (in_kind == KIND_LOAD && !predicted.load_accepted) loads_refused++;
        if (predicted.frame_done) frames_latched++;
        if (predicted.underrun) underruns_seen++;
        expected_line_q.push_back(use_typed ? typed_res : predicted);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("led_chain_pulse_width_encoder test failed");
    $finish;
  end

  task automatic send_item(input kind_t kind, input logic [PIXEL_W-1:0] word,
                           input logic last, input bit typed, input res_t tres);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_pixel_word <= word;
    in_last_pixel <= last;
    use_typed = typed;
    typed_res = tres;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] zero_high, input logic [CFG_W-1:0] one_high,
                            input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] latch);
    write_reg(REG_ZERO_HIGH, zero_high);
    write_reg(REG_ONE_HIGH, one_high);
    write_reg(REG_BIT_PERIOD, period);
    write_reg(REG_LATCH_LOW, latch);
  endtask

  // hold off new requests until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_line_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_frames(input int n_items);
    logic [PIXEL_W-1:0] word;
    for (int i = 0; i < n_items; i++) begin
      if (starve_left != 0) starve_left--;
      else if ($urandom_range(0, 249) == 0) starve_left = $urandom_range(40, 250);
      word = PIXEL_W'($urandom());
      if (!held_valid && starve_left == 0 && $urandom_range(0, 3) != 0) begin
        send_item(KIND_LOAD, word, pixels_to_go == 1, 1'b0, RES_QUIET);
        pixels_to_go = (pixels_to_go == 1) ? $urandom_range(1, 5) : pixels_to_go - 1;
      end else if ($urandom_range(0, 24) == 0) begin
        send_item(KIND_LOAD, word, 1'($urandom_range(0, 1)), 1'b0, RES_QUIET);
      end else begin
        send_item(KIND_TICK, word, 1'($urandom_range(0, 1)), 1'b0, RES_QUIET);
      end
    end
  endtask

  initial begin
    int               n_items;
    logic [CFG_W-1:0] zh, oh, per, lat;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero period and latch, zero-length low bit, full-scale high bit
    set_timing(16'd0, 16'hFFFF, 16'd0, 16'd0);
    foreach (directed_rows[i]) begin
      for (int rep = 0; rep < directed_rows[i].reps; rep++)
        send_item(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].res);
    end
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      n_items = 230;
      if (ph == 0) begin
        zh  = 16'd1;
        oh  = 16'd2;
        per = 16'd2;
        lat = 16'd1;
      end else if (ph == 1) begin
        zh  = '1;
        oh  = '1;
        per = '1;
        lat = '1;
        n_items = 150;
      end else begin
        per = CFG_W'($urandom_range(0, 6));
        zh  = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, per + 1));
        oh  = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, per + 1));
        lat = CFG_W'($urandom_range(0, 24));
      end
      sender_idles    = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      receiver_stalls = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      set_timing(zh, oh, per, lat);
      run_frames(n_items);
      settle();
    end
    repeat (16) @(negedge clk);
    fail_count += expected_line_q.size();

    $display("covered %0d requests: %0d pixels taken, %0d loads refused, %0d frames latched",
             requests_taken, pixels_taken, loads_refused, frames_latched);
    $display("%0d underruns seen over %0d timing settings, zero through full scale",
             underruns_seen, PHASES + 1);
    if (fail_count == 0) begin
      $display("led_chain_pulse_width_encoder test passed");
    end else begin
      $display("led_chain_pulse_width_encoder test failed");
    end
    $finish;
  end

endmodule
